FILE: rtl/ppd_pkg.sv
// Shared types, constants and the axis clamp function for the pointer packet decoder.
// Used by ppd_decode and pointer_packet_decoder; depends on nothing else.
package ppd_pkg;

	localparam int COORD_BITS = 12;
	localparam int CMP_W = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
	localparam int DELTA_W = 9;

	localparam logic [2:0] REG_PROTOCOL = 3'd0;
	localparam logic [2:0] REG_X_LOW    = 3'd1;
	localparam logic [2:0] REG_X_LIMIT  = 3'd2;
	localparam logic [2:0] REG_Y_LOW    = 3'd3;
	localparam logic [2:0] REG_Y_LIMIT  = 3'd4;

	localparam logic PROTO_PS2    = 1'b0;
	localparam logic PROTO_SERIAL = 1'b1;

	localparam logic [12:0] X_LIMIT_RST = 13'd640;
	localparam logic [12:0] Y_LIMIT_RST = 13'd480;
	localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(X_LIMIT_RST >> 1);
	localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(Y_LIMIT_RST >> 1);

	localparam logic signed [CMP_W-1:0] COORD_MAX_W = CMP_W'((1 << COORD_BITS) - 1);

	typedef struct packed {
		logic [2:0]                 buttons;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
	} ppd_dec_t;

	// Adds the delta and clamps: below low goes to low, else above the upper bound
	// goes to the upper bound. Both bounds saturate at the largest coordinate.
	function automatic logic [COORD_BITS-1:0] clamp_axis(
		input logic [COORD_BITS-1:0]    cur,
		input logic signed [DELTA_W-1:0] delta,
		input logic [11:0]              low,
		input logic [12:0]              limit
	);
		logic signed [CMP_W-1:0] v;
		logic signed [CMP_W-1:0] lo;
		logic signed [CMP_W-1:0] hi;
		logic signed [CMP_W-1:0] res;
		v = $signed(CMP_W'(cur)) + CMP_W'(delta);
		lo = $signed(CMP_W'(low));
		hi = (limit == 13'd0) ? '0 : $signed(CMP_W'(limit) - CMP_W'(1));
		if (lo > COORD_MAX_W) begin
			lo = COORD_MAX_W;
		end
		if (hi > COORD_MAX_W) begin
			hi = COORD_MAX_W;
		end
		if (v < lo) begin
			res = lo;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = v;
		end
		return res[COORD_BITS-1:0];
	endfunction

endpackage

FILE: rtl/pointer_packet_decoder.sv
// Top level of the pointer packet decoder: byte gathering, position update and result register.
// Depends on ppd_pkg and ppd_decode.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   data_byte
//   out      output     out_valid/out_stall pos_x, pos_y, buttons, button_changes, moved
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item is taken into an input register, then decoded, added and clamped combinationally
// into the result register, so a new byte can be accepted every cycle unless the input register is stalled.
// Bytes pass the input register, then the result register; only every third makes a result.
// A held result stalls the input register only when its byte closes a packet.
// Reset puts the position at half the reset window and clears the byte count and buttons.
module pointer_packet_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ppd_pkg::COORD_BITS-1:0] pos_x,
	output logic [ppd_pkg::COORD_BITS-1:0] pos_y,
	output logic [2:0]                    buttons,
	output logic [2:0]                    button_changes,
	output logic                          moved,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [12:0]                   cfg_data
);
	import ppd_pkg::*;

	logic                  protocol_q;
	logic [11:0]           x_low_q;
	logic [12:0]           x_limit_q;
	logic [11:0]           y_low_q;
	logic [12:0]           y_limit_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic [1:0]            byte_cnt_q;
	logic [7:0]            store_q [2];
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [2:0]            button_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [2:0]            buttons_q;
	logic [2:0]            changes_q;
	logic                  moved_q;

	logic                  s1_last;
	logic                  s1_go;
	logic                  s1_fire;
	ppd_dec_t              dec;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= PROTO_PS2;
			x_low_q    <= '0;
			x_limit_q  <= X_LIMIT_RST;
			y_low_q    <= '0;
			y_limit_q  <= Y_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROTOCOL: protocol_q <= cfg_data[0];
				REG_X_LOW:    x_low_q    <= cfg_data[11:0];
				REG_X_LIMIT:  x_limit_q  <= cfg_data;
				REG_Y_LOW:    y_low_q    <= cfg_data[11:0];
				REG_Y_LIMIT:  y_limit_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s1_last  = (byte_cnt_q == 2'd2);
	assign s1_go    = !s1_last || !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;

	ppd_decode u_decode (
		.protocol (protocol_q),
		.b0       (store_q[0]),
		.b1       (store_q[1]),
		.b2       (byte_s1),
		.dec      (dec)
	);

	assign next_x = clamp_axis(cur_x_q, dec.dx, x_low_q, x_limit_q);
	assign next_y = clamp_axis(cur_y_q, dec.dy, y_low_q, y_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !s1_last) begin
			store_q[byte_cnt_q[0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			cur_x_q    <= POS_X_RST;
			cur_y_q    <= POS_Y_RST;
			button_q   <= '0;
		end else if (s1_fire) begin
			if (s1_last) begin
				byte_cnt_q <= '0;
				cur_x_q    <= next_x;
				cur_y_q    <= next_y;
				button_q   <= dec.buttons;
			end else begin
				byte_cnt_q <= byte_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_last) begin
			pos_x_q   <= next_x;
			pos_y_q   <= next_y;
			buttons_q <= dec.buttons;
			changes_q <= dec.buttons ^ button_q;
			moved_q   <= (dec.dx != '0) || (dec.dy != '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign pos_x          = pos_x_q;
	assign pos_y          = pos_y_q;
	assign buttons        = buttons_q;
	assign button_changes = changes_q;
	assign moved          = moved_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q != 2'd3)
		else $error("byte count left its range");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && s1_last && out_valid_q))
		else $error("input stalled without a held result");

	a_result_made: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_last) |=> (out_valid_q && byte_cnt_q == 2'd0))
		else $error("closing byte did not produce a result");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !s1_last) |=> (byte_cnt_q == $past(byte_cnt_q) + 2'd1))
		else $error("byte count did not advance");

	a_button_track: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_last) |=> (button_q == buttons_q && cur_x_q == pos_x_q))
		else $error("stored state disagrees with the result");

endmodule

FILE: rtl/ppd_decode.sv
// Decodes one three-byte packet into buttons and signed deltas for either protocol.
// Depends on ppd_pkg.
module ppd_decode (
	input  logic              protocol,
	input  logic [7:0]        b0,
	input  logic [7:0]        b1,
	input  logic [7:0]        b2,
	output ppd_pkg::ppd_dec_t dec
);
	import ppd_pkg::*;

	logic [DELTA_W-1:0] ps2_dy_raw;

	assign ps2_dy_raw = {b0[5], b2};

	always_comb begin
		dec = '0;
		case (protocol)
			PROTO_PS2: begin
				dec.buttons = {b0[1], b0[2], b0[0]};
				dec.dx = (b1 == 8'd0) ? '0 : $signed({b0[4], b1});
				dec.dy = (b2 == 8'd0) ? '0 : $signed(DELTA_W'(0) - ps2_dy_raw);
			end
			PROTO_SERIAL: begin
				dec.buttons = {1'b0, b1[4], b0[5]};
				dec.dx = DELTA_W'($signed({b0[1:0], b1[5:0]}));
				dec.dy = DELTA_W'($signed({b0[3:2], b2[5:0]}));
			end
			default: begin
				dec = '0;
			end
		endcase
	end

endmodule

FILE: verif/ppd_motion_checker.sv
// Checker for the pointer packet decoder: follows accepted bytes and register writes,
// tracks position and buttons, and compares each result item in order.
// Depends on ppd_pkg for the coordinate width and the register and protocol codes.
module ppd_motion_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [ppd_pkg::COORD_BITS-1:0] pos_x,
	input  logic [ppd_pkg::COORD_BITS-1:0] pos_y,
	input  logic [2:0]                     buttons,
	input  logic [2:0]                     button_changes,
	input  logic                           moved,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [12:0]                    cfg_data,
	input  logic                           run_done,
	output int                             fail_count,
	output int                             pending,
	output int                             packets
);
	timeunit 1ns;
	timeprecision 1ps;

	import ppd_pkg::*;

	localparam int COORD_MAX = (1 << COORD_BITS) - 1;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [2:0]            btn;
		logic [2:0]            chg;
		logic                  mv;
	} motion_t;

	motion_t           motion_q[$];
	motion_t           want;
	motion_t           got;
	logic              proto;
	int                x_low_r;
	int                x_lim_r;
	int                y_low_r;
	int                y_lim_r;
	logic [7:0]        held [2];
	int                held_cnt;
	int                track_x;
	int                track_y;
	logic [2:0]        btn_state;
	logic [2:0]        nb;
	int                dx;
	int                dy;
	logic signed [7:0] sx;
	logic signed [7:0] sy;
	int                errors = 0;
	int                checked = 0;

	assign fail_count = errors;
	assign packets = checked;

	task automatic report(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic int clamp_coord(input int v, input int low_reg, input int limit_reg);
		int lo;
		int hi;
		lo = low_reg;
		hi = (limit_reg == 0) ? 0 : limit_reg - 1;
		if (lo > COORD_MAX) begin
			lo = COORD_MAX;
		end
		if (hi > COORD_MAX) begin
			hi = COORD_MAX;
		end
		if (v < lo) begin
			return lo;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto = PROTO_PS2;
			x_low_r = 0;
			x_lim_r = int'(X_LIMIT_RST);
			y_low_r = 0;
			y_lim_r = int'(Y_LIMIT_RST);
			held_cnt = 0;
			track_x = int'(X_LIMIT_RST) / 2;
			track_y = int'(Y_LIMIT_RST) / 2;
			btn_state = '0;
			motion_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_PROTOCOL: begin
					proto = cfg_data[0];
				end
				REG_X_LOW: begin
					x_low_r = int'(cfg_data[11:0]);
				end
				REG_X_LIMIT: begin
					x_lim_r = int'(cfg_data);
				end
				REG_Y_LOW: begin
					y_low_r = int'(cfg_data[11:0]);
				end
				REG_Y_LIMIT: begin
					y_lim_r = int'(cfg_data);
				end
				default: begin
				end
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {pos_x, pos_y, buttons, button_changes, moved};
				if (motion_q.size() == 0) begin
					report($sformatf("result x=%0d y=%0d with none expected", pos_x, pos_y));
				end else begin
					want = motion_q.pop_front();
					checked++;
					if (got.x != want.x) begin
						report($sformatf("pos_x %0d, expected %0d", got.x, want.x));
					end
					if (got.y != want.y) begin
						report($sformatf("pos_y %0d, expected %0d", got.y, want.y));
					end
					if (got.btn != want.btn) begin
						report($sformatf("buttons %b, expected %b", got.btn, want.btn));
					end
					if (got.chg != want.chg) begin
						report($sformatf("button_changes %b, expected %b", got.chg, want.chg));
					end
					if (got.mv != want.mv) begin
						report($sformatf("moved %b, expected %b", got.mv, want.mv));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (held_cnt < 2) begin
					held[held_cnt[0]] = data_byte;
					held_cnt++;
				end else begin
					held_cnt = 0;
					if (proto == PROTO_PS2) begin
						nb = {held[0][1], held[0][2], held[0][0]};
						if (held[1] == 8'h00) begin
							dx = 0;
						end else begin
							dx = held[0][4] ? int'(held[1]) - 256 : int'(held[1]);
						end
						if (data_byte == 8'h00) begin
							dy = 0;
						end else begin
							dy = held[0][5] ? 256 - int'(data_byte) : -int'(data_byte);
						end
					end else begin
						nb = {1'b0, held[1][4], held[0][5]};
						sx = {held[0][1:0], held[1][5:0]};
						sy = {held[0][3:2], data_byte[5:0]};
						dx = sx;
						dy = sy;
					end
					track_x = clamp_coord(track_x + dx, x_low_r, x_lim_r);
					track_y = clamp_coord(track_y + dy, y_low_r, y_lim_r);
					want.x = track_x[COORD_BITS-1:0];
					want.y = track_y[COORD_BITS-1:0];
					want.btn = nb;
					want.chg = nb ^ btn_state;
					want.mv = (dx != 0) || (dy != 0);
					btn_state = nb;
					motion_q.push_back(want);
				end
			end
			if (run_done && motion_q.size() != 0) begin
				report($sformatf("%0d expected results never arrived", motion_q.size()));
			end
			pending <= motion_q.size();
		end
	end

endmodule

FILE: verif/pointer_packet_decoder_test.sv
// Testbench top for the pointer packet decoder: clock, reset, byte and register stimulus,
// receiver stalls and the verdict. Depends on ppd_pkg, the block and ppd_motion_checker.
module pointer_packet_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppd_pkg::*;

	localparam int DRAIN_CYCLES = 4;
	localparam int LIMIT_CYCLES = 600000;
	localparam int LONG_HOLD    = 200;
	localparam int BYTE_GOAL    = 1924;
	localparam int HOLD_PHASE   = 3;
	localparam int QUIET_PHASE  = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [2:0]            buttons;
	logic [2:0]            button_changes;
	logic                  moved;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [2:0]            cfg_index = '0;
	logic [12:0]           cfg_data = '0;
	logic                  run_done = 1'b0;
	int                    fail_count;
	int                    pending;
	int                    packets;

	bit                    hold_request = 1'b0;
	bit                    quiet = 1'b0;
	bit                    run_stall = 1'b0;
	int                    hold_left = 0;
	int                    run_left = 0;
	int                    bytes_sent = 0;
	int                    settings_done = 0;
	int                    cycle_count = 0;

	always #6 clk = ~clk;

	pointer_packet_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .buttons(buttons),
		.button_changes(button_changes), .moved(moved),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ppd_motion_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .buttons(buttons),
		.button_changes(button_changes), .moved(moved),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.run_done(run_done), .fail_count(fail_count),
		.pending(pending), .packets(packets)
	);

	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] make_byte(input int slot);
		int r;
		r = $urandom_range(0, 99);
		if (slot == 0 || r >= 70) begin
			return 8'($urandom_range(0, 255));
		end else if (r < 25) begin
			return 8'h00;
		end else if (r < 45) begin
			case ($urandom_range(0, 3))
			0: begin
				return 8'h01;
			end
			1: begin
				return 8'h7F;
			end
			2: begin
				return 8'h80;
			end
			default: begin
				return 8'hFF;
			end
			endcase
		end
		return 8'($urandom_range(1, 12));
	endfunction

	task automatic send_byte(input logic [7:0] value, input int gap);
		in_valid <= 1'b1;
		data_byte <= value;
		do begin
			@(posedge clk);
		end while (in_stall);
		bytes_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		send_byte(b0, pick_gap());
		send_byte(b1, pick_gap());
		send_byte(b2, pick_gap());
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [12:0] proto, input logic [12:0] xlo,
			input logic [12:0] xlim, input logic [12:0] ylo, input logic [12:0] ylim);
		write_reg(REG_PROTOCOL, proto);
		write_reg(REG_X_LOW, xlo);
		write_reg(REG_X_LIMIT, xlim);
		write_reg(REG_Y_LOW, ylo);
		write_reg(REG_Y_LIMIT, ylim);
		settings_done++;
	endtask

	task automatic pick_axis(output logic [12:0] lo, output logic [12:0] lim);
		case ($urandom_range(0, 7))
		0: begin
			lo = '0;
			lim = 13'd4096;
		end
		1, 2, 3: begin
			lo = 13'($urandom_range(0, 2000));
			lim = lo + 13'($urandom_range(1, 2000));
		end
		4: begin
			lo = 13'($urandom_range(0, 4095));
			lim = lo + 13'd1;
		end
		5: begin
			lo = 13'($urandom_range(0, 100));
			lim = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4097, 8191));
		end
		6: begin
			lo = 13'($urandom_range(1000, 4095));
			lim = 13'($urandom_range(1, 999));
		end
		default: begin
			lo = 13'($urandom_range(0, 8191));
			lim = 13'($urandom_range(0, 8191));
		end
		endcase
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					case ($urandom_range(0, 99)) inside
					[0:54]: begin
						run_stall = 1'b0;
						run_left = $urandom_range(1, 12);
					end
					[55:91]: begin
						run_stall = 1'b1;
						run_left = $urandom_range(1, 3);
					end
					default: begin
						run_stall = 1'b1;
						run_left = $urandom_range(10, 40);
					end
					endcase
				end
				out_stall <= run_stall;
				run_left--;
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
		$display("** pointer_packet_decoder: FAILED **");
		$finish;
	end

	initial begin
		int phase;
		int phase_len;
		int pause_at;
		logic [12:0] xlo;
		logic [12:0] xlim;
		logic [12:0] ylo;
		logic [12:0] ylim;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_packet(8'h00, 8'h00, 8'h00);
		send_packet(8'h37, 8'h00, 8'h00);
		send_packet(8'h30, 8'h01, 8'hFF);
		send_packet(8'h00, 8'hFF, 8'h80);
		send_byte(8'h2F, pick_gap());
		send_byte(8'h3F, pick_gap());
		settle();
		write_reg(REG_PROTOCOL, 13'(PROTO_SERIAL));
		send_byte(8'h3F, pick_gap());
		send_packet(8'hFF, 8'hFF, 8'hFF);
		send_packet(8'h05, 8'h3F, 8'h3F);
		send_packet(8'h0A, 8'h00, 8'h00);
		settle();

		phase = 0;
		while (bytes_sent < BYTE_GOAL) begin
			case (phase)
			0: begin
				apply_setting(13'(PROTO_PS2), 13'd0, 13'd4096, 13'd0, 13'd4096);
			end
			1: begin
				apply_setting(13'(PROTO_SERIAL), 13'd4095, 13'd4096, 13'd0, 13'd1);
			end
			2: begin
				apply_setting(13'(PROTO_PS2), 13'd0, 13'd0, 13'd100, 13'd8191);
			end
			default: begin
				pick_axis(xlo, xlim);
				pick_axis(ylo, ylim);
				apply_setting(13'($urandom_range(0, 8191)), xlo, xlim, ylo, ylim);
			end
			endcase
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_Y_LIMIT + 3'($urandom_range(1, 3)), 13'($urandom_range(0, 8191)));
			end
			quiet = (phase == QUIET_PHASE);
			if (phase == HOLD_PHASE) begin
				hold_request = 1'b1;
			end
			phase_len = $urandom_range(90, 180);
			pause_at = $urandom_range(10, phase_len - 10);
			for (int i = 0; i < phase_len; i++) begin
				if (i == pause_at) begin
					settle();
				end
				send_byte(make_byte(bytes_sent % 3),
					(phase == HOLD_PHASE && i < 60) ? 0 : pick_gap());
			end
			settle();
			quiet = 1'b0;
			phase++;
		end

		run_done <= 1'b1;
		@(posedge clk);
		run_done <= 1'b0;
		repeat (2) @(posedge clk);

		$display("Run covered %0d bytes and %0d checked packets under %0d register settings,",
			bytes_sent, packets, settings_done);
		$display("both protocols, window extremes, a long output hold and %0d mismatches.",
			fail_count);
		if (fail_count == 0) begin
			$display("** pointer_packet_decoder: PASSED **");
		end else begin
			$display("** pointer_packet_decoder: FAILED **");
		end
		$finish;
	end

endmodule
